// File: rtl/nearest_linked_station_search_assert.svh
`ifndef NEAREST_LINKED_STATION_SEARCH_ASSERT_SVH
`define NEAREST_LINKED_STATION_SEARCH_ASSERT_SVH

// same-cycle implication on i_clk, off during reset
`define NLSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on i_clk, off during reset
`define NLSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nlss_pkg.sv
package nlss_pkg;

    localparam int STATION_W = 32;
    localparam int DIST_W    = 32;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [STATION_W-1:0] e2;
        logic [STATION_W-1:0] e1;
    } t_link;

    typedef struct packed {
        logic  vld;
        logic  first;
        t_link link;
    } t_feed;

endpackage

// File: rtl/nearest_linked_station_search.sv
// channel  | dir | tdata                                  | tuser
// s_axis   | in  | [31:0] station_a, [63:32] station_b    | [0] action
// m_axis   | out | [31:0] distance                        | [0] table_full
//
// add: at most one memory write; on a full table nothing is written and table_full is set
// query: one stored link read per cycle from the link memory
// one item at a time; the next item is taken while a result waits in the output register
// synchronous active-low reset clears the link count; the link memory keeps no reset
// a stalled m_axis holds the block in its emit step until the output register frees

`include "nearest_linked_station_search_assert.svh"

module nearest_linked_station_search #(
    parameter int LINK_CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // station_a, station_b
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // distance
    output logic [0:0]  m_axis_tuser    // table_full
);
    import nlss_pkg::*;

    localparam int AW = (LINK_CAPACITY > 1) ? $clog2(LINK_CAPACITY) : 1;
    localparam int CW = $clog2(LINK_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(LINK_CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic                  r_first;
    logic                  r_rd_vld;
    logic                  r_drain;
    logic [STATION_W-1:0]  r_a;
    logic [STATION_W-1:0]  r_b;
    logic [DIST_W-1:0]     r_res_dist;
    logic                  r_res_full;
    logic                  r_out_valid;
    logic [DIST_W-1:0]     r_out_data;
    logic                  r_out_full;

    logic                  w_in_accept;
    logic                  w_wr_en;
    logic                  w_rd_en;
    t_link                 w_wr_link;
    t_link                 w_rd_link;
    t_feed                 w_feed;
    logic [DIST_W-1:0]     w_best;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_wr_en       = w_in_accept && (s_axis_tuser[0] == ACT_ADD) && (r_count < CAP);
    assign w_rd_en       = (r_state == S_SCAN) && (r_idx < r_count);
    assign w_wr_link.e1  = s_axis_tdata[31:0];
    assign w_wr_link.e2  = s_axis_tdata[63:32];

    nlss_link_mem #(
        .DEPTH (LINK_CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_link),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_link)
    );

    // first feed is the direct path, a self link on start
    always_comb begin
        w_feed.vld   = r_first || r_rd_vld;
        w_feed.first = r_first;
        if (r_first) begin
            w_feed.link.e1 = r_a;
            w_feed.link.e2 = r_a;
        end else begin
            w_feed.link = w_rd_link;
        end
    end

    nlss_min_unit u_min (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_feed   (w_feed),
        .i_start  (r_a),
        .i_target (r_b),
        .o_best   (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_first     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        if (s_axis_tuser[0] == ACT_ADD) begin
                            r_res_dist <= '0;
                            r_res_full <= !(r_count < CAP);
                            if (w_wr_en) begin
                                r_count <= r_count + CW'(1);
                            end
                            r_state <= S_EMIT;
                        end else begin
                            r_a     <= s_axis_tdata[31:0];
                            r_b     <= s_axis_tdata[63:32];
                            r_idx   <= '0;
                            r_first <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_first <= 1'b0;
                    if (w_rd_en) begin
                        r_idx    <= r_idx + CW'(1);
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                        r_drain  <= 1'b0;
                        r_state  <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // wait on r_drain so the last link passes the stage 1 registers and folds into r_best
                    if (r_drain) begin
                        r_res_dist <= w_best;
                        r_res_full <= 1'b0;
                        r_state    <= S_EMIT;
                    end else begin
                        r_drain <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res_dist;
                        r_out_full  <= r_res_full;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_full;

    `NLSS_ASSERT_NXT(a_full_keeps_count,
        w_in_accept && s_axis_tuser[0] == ACT_ADD && r_count == CAP,
        r_count == $past(r_count), "add on full table changed the link count")
    `NLSS_ASSERT_IMP(a_full_has_zero_dist, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata == '0, "dropped add reported a nonzero distance")
    `NLSS_ASSERT_IMP(a_write_below_cap, w_wr_en,
        r_count < CAP && r_state == S_IDLE, "link write outside idle or past capacity")
    `NLSS_ASSERT_IMP(a_read_in_range, r_rd_vld,
        r_idx <= r_count && r_idx != '0, "link read data beyond the stored count")

endmodule

// File: rtl/nlss_link_mem.sv
module nlss_link_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  nlss_pkg::t_link i_wr_data,
    input  logic           i_rd_en,
    input  logic [AW-1:0]  i_rd_addr,
    output nlss_pkg::t_link o_rd_data
);
    import nlss_pkg::*;

    t_link r_mem [DEPTH];
    t_link r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/nlss_min_unit.sv
module nlss_min_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nlss_pkg::t_feed            i_feed,
    input  logic [nlss_pkg::STATION_W-1:0] i_start,
    input  logic [nlss_pkg::STATION_W-1:0] i_target,
    output logic [nlss_pkg::DIST_W-1:0]    o_best
);
    import nlss_pkg::*;

    function automatic logic [DIST_W-1:0] gap(input logic [STATION_W-1:0] p,
                                              input logic [STATION_W-1:0] q);
        logic [DIST_W-1:0] d;
        if ($signed(p) >= $signed(q)) begin
            d = p - q;
        end else begin
            d = q - p;
        end
        return d;
    endfunction

    logic              r_s1_vld;
    logic              r_s1_first;
    logic [DIST_W-1:0] r_c1;
    logic [DIST_W-1:0] r_c2;
    logic [DIST_W-1:0] r_best;
    logic [DIST_W-1:0] n_c1;
    logic [DIST_W-1:0] n_c2;
    logic [DIST_W-1:0] n_best;
    logic [DIST_W-1:0] w_min12;
    logic [DIST_W-1:0] w_base;

    // stage 1: match either end, gap to the far end
    always_comb begin
        n_c1 = '1;
        n_c2 = '1;
        if (i_feed.link.e1 == i_start) begin
            n_c1 = gap(i_target, i_feed.link.e2);
        end
        if (i_feed.link.e2 == i_start) begin
            n_c2 = gap(i_target, i_feed.link.e1);
        end
    end

    // stage 2: fold into running minimum
    always_comb begin
        w_min12 = (r_c1 < r_c2) ? r_c1 : r_c2;
        w_base  = r_s1_first ? '1 : r_best;
        n_best  = (w_min12 < w_base) ? w_min12 : w_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s1_first <= 1'b0;
        end else begin
            r_s1_vld   <= i_feed.vld;
            r_s1_first <= i_feed.first;
        end
        r_c1 <= n_c1;
        r_c2 <= n_c2;
        if (r_s1_vld) begin
            r_best <= n_best;
        end
    end

    assign o_best = r_best;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nlss_pkg::*;

    localparam int LINK_SLOTS    = 256;
    localparam int IDLE_PCT      = 36;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 150;
    localparam int RANDOM_ITEMS  = 980;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic                 action;
        logic [STATION_W-1:0] sta;
        logic [STATION_W-1:0] stb;
        bit                   drain;
        bit                   eager;
    } station_item_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              full;
    } search_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // [31:0] station_a, [63:32] station_b
    logic [0:0]  s_axis_tuser = '0;   // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] distance
    logic [0:0]  m_axis_tuser;        // [0] table_full

    station_item_t  pending_q[$];
    station_item_t  on_wire;
    search_result_t dist_expect_q[$];

    logic [STATION_W-1:0] link_one_tab [LINK_SLOTS];
    logic [STATION_W-1:0] link_two_tab [LINK_SLOTS];
    int                   links_held = 0;

    logic [STATION_W-1:0] hub_pool [12];
    int error_count  = 0;
    int result_count = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    nearest_linked_station_search #(
        .LINK_CAPACITY(LINK_SLOTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [DIST_W-1:0] span_between(logic [31:0] p, logic [31:0] q);
        if ($signed(p) >= $signed(q)) begin
            return p - q;
        end
        return q - p;
    endfunction

    task automatic predict_station_item(station_item_t it);
        search_result_t res;
        logic [DIST_W-1:0] d;
        res.distance = '0;
        res.full = 1'b0;
        if (it.action == ACT_ADD) begin
            if (links_held < LINK_SLOTS) begin
                link_one_tab[links_held] = it.sta;
                link_two_tab[links_held] = it.stb;
                links_held++;
            end else begin
                res.full = 1'b1;
            end
        end else begin
            res.distance = span_between(it.sta, it.stb);
            for (int k = 0; k < links_held; k++) begin
                if (link_one_tab[k] == it.sta) begin
                    d = span_between(it.stb, link_two_tab[k]);
                    if (d < res.distance) res.distance = d;
                end
                if (link_two_tab[k] == it.sta) begin
                    d = span_between(it.stb, link_one_tab[k]);
                    if (d < res.distance) res.distance = d;
                end
            end
        end
        dist_expect_q.push_back(res);
    endtask

    task automatic queue_item(logic act, logic [31:0] a, logic [31:0] b, bit drain, bit eager);
        station_item_t it;
        it.action = act;
        it.sta    = a;
        it.stb    = b;
        it.drain  = drain;
        it.eager  = eager;
        pending_q.push_back(it);
    endtask

    function automatic logic [31:0] pick_station();
        if ($urandom_range(0, 99) < 80) begin
            return hub_pool[$urandom_range(0, 11)];
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_target();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            return $urandom;
        end else if (sel < 70) begin
            return hub_pool[$urandom_range(0, 11)];
        end
        return hub_pool[$urandom_range(0, 11)] + $urandom_range(0, 100) - 50;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_station_item(on_wire);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() > 0
                        && !(pending_q[0].drain && dist_expect_q.size() > 0)
                        && (pending_q[0].eager || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    on_wire = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {on_wire.stb, on_wire.sta};
                    s_axis_tuser  <= on_wire.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        search_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (dist_expect_q.size() == 0) begin
                    $error("result item with no expectation: distance %0d table_full %0d",
                           m_axis_tdata, m_axis_tuser);
                    error_count++;
                end else begin
                    want = dist_expect_q.pop_front();
                    if (m_axis_tdata !== want.distance) begin
                        $error("distance mismatch: expected %0d, got %0d",
                               want.distance, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== want.full) begin
                        $error("table_full mismatch: expected %0d, got %0d",
                               want.full, m_axis_tuser[0]);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && result_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (result_count >= 400 && result_count < 520) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        hub_pool[0] = INT_MIN;
        hub_pool[1] = INT_MAX;
        hub_pool[2] = 32'h0;
        hub_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 12; i++) begin
            hub_pool[i] = $urandom;
        end

        // empty table, extreme spans
        queue_item(ACT_QUERY, INT_MIN, INT_MAX, 1'b0, 1'b0);
        queue_item(ACT_QUERY, INT_MAX, INT_MIN, 1'b0, 1'b0);
        queue_item(ACT_QUERY, 32'h0, 32'h0, 1'b0, 1'b0);
        // self link
        queue_item(ACT_ADD, 32'd5, 32'd5, 1'b0, 1'b0);
        queue_item(ACT_QUERY, 32'd5, 32'd6, 1'b0, 1'b0);
        // extremes linked, matched at either end
        queue_item(ACT_ADD, INT_MIN, INT_MAX, 1'b0, 1'b0);
        queue_item(ACT_QUERY, INT_MAX, INT_MIN, 1'b0, 1'b0);
        queue_item(ACT_QUERY, INT_MIN, INT_MAX, 1'b0, 1'b0);
        // duplicate links and second-end match
        queue_item(ACT_ADD, 32'd10, 32'd1000, 1'b0, 1'b0);
        queue_item(ACT_ADD, 32'd10, 32'd1000, 1'b0, 1'b0);
        queue_item(ACT_ADD, 32'd2000, 32'd10, 1'b0, 1'b0);
        queue_item(ACT_QUERY, 32'd10, 32'd1990, 1'b0, 1'b0);
        queue_item(ACT_QUERY, 32'd10, -32'sd5, 1'b0, 1'b0);
        queue_item(ACT_ADD, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        queue_item(ACT_QUERY, 32'hFFFF_FFFF, 32'd1, 1'b0, 1'b0);
        queue_item(ACT_ADD, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0, 1'b0);
        queue_item(ACT_QUERY, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0, 1'b0);
        queue_item(ACT_QUERY, 32'h1234_5678, 32'hDEAD_BEF0, 1'b0, 1'b0);
        // start without links
        queue_item(ACT_QUERY, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 45) begin
                queue_item(ACT_ADD, pick_station(), pick_station(),
                           (n == 0 || n == 600 || n == 850), (n >= 300 && n < 420));
            end else begin
                queue_item(ACT_QUERY, pick_station(), pick_target(),
                           (n == 0 || n == 600 || n == 850), (n >= 300 && n < 420));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (dist_expect_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
